// ===== design/qjt_pkg.sv =====
`default_nettype none

package qjt_pkg;

   // Fixed-point format and field widths.
   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 32;
   localparam int TIME_W    = 32;
   localparam int STEP_W    = 16;
   localparam int GEAR_W    = 24;
   localparam int FUNC_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // Request and response packing.
   localparam int REQ_DATA_W = POS_W + TIME_W;
   localparam int RSP_DATA_W = 2 * POS_W;
   localparam int RSP_USER_W = 2;

   // Curve polynomial 10 - 15*tau + 6*tau^2, scaled by 2^FRAC_BITS.
   localparam int POLY_TEN     = 10;
   localparam int POLY_FIFTEEN = 15;
   localparam int POLY_SIX     = 6;
   localparam int POLY_W       = FRAC_BITS + 4;
   localparam int POLY_CALC_W  = FRAC_BITS + 6;

   // Shared multiplier: unsigned magnitude times unsigned factor.
   localparam int MUL_A_W   = POS_W + 1;
   localparam int MUL_B_W   = (GEAR_W > POLY_W) ? GEAR_W : POLY_W;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int ANG_MAG_W = MUL_P_W - FRAC_BITS;

   // Divider step counter.
   localparam int DIV_CNT_W = $clog2(FRAC_BITS + 1);

   // Reset values of the control registers.
   localparam logic [STEP_W-1:0] TIME_STEP_RESET = STEP_W'(66);
   localparam logic [GEAR_W-1:0] GEAR_RESET      = GEAR_W'(1 << FRAC_BITS);
   localparam logic [POS_W-1:0]  POS_MIN         = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [POS_W-1:0]  POS_MAX         = {1'b0, {(POS_W-1){1'b1}}};

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_MOVE  = 2'd1,
      FUNC_FORCE = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIME_STEP   = 3'd0,
      CSR_LOWER_LIMIT = 3'd1,
      CSR_UPPER_LIMIT = 3'd2,
      CSR_ZERO_OFFSET = 3'd3,
      CSR_REVERSE     = 3'd4,
      CSR_GEAR_RATIO  = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIVIDE,
      ST_TAU2,
      ST_TAU3,
      ST_SCALE,
      ST_POS,
      ST_POS_DONE,
      ST_MOTOR,
      ST_MOTOR_DONE,
      ST_FINISH
   } state_type;

   // Start command and operands for the tau divider.
   typedef struct packed {
      logic              start;
      logic [TIME_W-1:0] dividend;
      logic [TIME_W-1:0] divisor;
   } div_req_type;

endpackage

`default_nettype wire

// ===== design/qjt_div.sv =====
`default_nettype none

// Restoring divider producing tau = (t << FRAC_BITS) / T for t < T, one quotient bit a cycle.
module qjt_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire qjt_pkg::div_req_type         div_req,
   output logic                              div_done,
   output logic [qjt_pkg::FRAC_BITS-1:0]     div_quot
);
   import qjt_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [TIME_W-1:0]    divisor_ff, divisor_in;
   logic [FRAC_BITS-1:0] quot_ff, quot_in;

   logic [TIME_W:0]      shifted;
   logic [TIME_W:0]      diff;
   logic                 fits;

   // One restoring step: the remainder stays below the divisor throughout.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, divisor_ff};
      fits    = shifted >= {1'b0, divisor_ff};
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = DIV_CNT_W'(FRAC_BITS);
         rem_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
         quot_in = {quot_ff[FRAC_BITS-2:0], fits};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign div_done = done_ff;
   assign div_quot = quot_ff;

endmodule

`default_nettype wire

// ===== design/qjt_mul.sv =====
`default_nettype none

// Shared unsigned multiplier with a registered product.
module qjt_mul (
   input  wire logic                         clock,
   input  wire logic [qjt_pkg::MUL_A_W-1:0]  mul_a,
   input  wire logic [qjt_pkg::MUL_B_W-1:0]  mul_b,
   output logic [qjt_pkg::MUL_P_W-1:0]       mul_p
);
   import qjt_pkg::*;

   logic [MUL_P_W-1:0] prod_ff, prod_in;

   always_comb begin
      prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

`default_nettype wire

// ===== design/quintic_joint_trajectory_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_tvalid/tready    tdata: target, duration; tuser: func
// rsp_      out        rsp_tvalid/tready    tdata: setpoint, motor_angle;
//                                           tuser: motor_valid, moving
// csr_      in         csr_valid/ready      csr_index, csr_data (always ready)
//
// One request is worked at a time; req_tready is high only while the sequencer idles.
// A tick during a move runs, from one acceptance to the next: decode, the restoring tau
// divider, seven steps for five shared multiplier passes, finish, idle. A tick that ends
// a move or finds none runs decode, the motor steps, finish and idle; any other request decode, finish, idle.
// The response register lets a request be taken while the previous response waits;
// a stalled response holds the sequencer in its final step. Reset is synchronous.
module quintic_joint_trajectory_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel.
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [qjt_pkg::REQ_DATA_W-1:0]  req_tdata,   // target, duration
   input  wire logic [qjt_pkg::FUNC_W-1:0]      req_tuser,   // func
   // Response channel.
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [qjt_pkg::RSP_DATA_W-1:0]       rsp_tdata,   // setpoint, motor_angle
   output logic [qjt_pkg::RSP_USER_W-1:0]       rsp_tuser,   // motor_valid, moving
   // Register write channel.
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [qjt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [qjt_pkg::CSR_DAT_W-1:0]   csr_data
);
   import qjt_pkg::*;

   // Control registers.
   logic [STEP_W-1:0] time_step_ff, time_step_in;
   logic [POS_W-1:0]  lower_limit_ff, lower_limit_in;
   logic [POS_W-1:0]  upper_limit_ff, upper_limit_in;
   logic [POS_W-1:0]  zero_offset_ff, zero_offset_in;
   logic              reverse_ff, reverse_in;
   logic [GEAR_W-1:0] gear_ff, gear_in;

   // Trajectory state.
   logic [POS_W-1:0]  start_ff, start_in;
   logic [POS_W-1:0]  end_ff, end_in;
   logic [TIME_W-1:0] move_time_ff, move_time_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic              planning_ff, planning_in;
   logic [POS_W-1:0]  setpoint_ff, setpoint_in;

   // Sequencer and working registers.
   state_type            state_ff, state_in;
   func_type             func_ff, func_in;
   logic [POS_W-1:0]     target_ff, target_in;
   logic [TIME_W-1:0]    duration_ff, duration_in;
   logic [FRAC_BITS-1:0] tau_ff, tau_in;
   logic [FRAC_BITS-1:0] tau2_ff, tau2_in;
   logic                 sign_ff, sign_in;
   logic [POS_W-1:0]     angle_ff, angle_in;
   logic                 motor_valid_ff, motor_valid_in;

   // Response register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_setpoint_ff, rsp_setpoint_in;
   logic [POS_W-1:0] rsp_angle_ff, rsp_angle_in;
   logic             rsp_motor_valid_ff, rsp_motor_valid_in;
   logic             rsp_moving_ff, rsp_moving_in;

   // Shared units.
   div_req_type          div_req;
   logic                 div_done;
   logic [FRAC_BITS-1:0] div_quot;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_P_W-1:0]   mul_p;

   // Intermediate values.
   logic                   req_fire;
   logic                   rsp_free;
   logic [TIME_W:0]        t_sum;
   logic                   t_done;
   logic                   target_ok;
   logic                   setpoint_ok;
   logic                   move_ok;
   logic                   div_go;
   logic [POLY_CALC_W-1:0] poly_raw;
   logic [POLY_W-1:0]      poly;
   logic [POS_W:0]         pos_diff;
   logic [POS_W:0]         pos_mag;
   logic [POS_W:0]         pos_step;
   logic [POS_W:0]         pos_delta;
   logic [POS_W:0]         mot_diff;
   logic [POS_W:0]         mot_mag;
   logic [ANG_MAG_W-1:0]   ang_mag;
   logic [POS_W-1:0]       ang_sat;

   qjt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   qjt_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   // Handshake qualifiers and shared decode terms.
   always_comb begin
      req_fire    = req_tvalid && req_tready;
      rsp_free    = !rsp_valid_ff || rsp_tready;
      t_sum       = {1'b0, elapsed_ff} + (TIME_W+1)'(time_step_ff);
      t_done      = t_sum >= {1'b0, move_time_ff};
      target_ok   = ($signed(target_ff) >= $signed(lower_limit_ff)) &&
                    ($signed(target_ff) <= $signed(upper_limit_ff));
      setpoint_ok = ($signed(setpoint_ff) >= $signed(lower_limit_ff)) &&
                    ($signed(setpoint_ff) <= $signed(upper_limit_ff));
      move_ok     = !planning_ff && target_ok && (duration_ff != '0);
      div_go      = (state_ff == ST_DECODE) && (func_ff == FUNC_TICK) &&
                    planning_ff && !t_done;
   end

   // Curve and motor arithmetic around the shared multiplier.
   always_comb begin
      poly_raw  = (POLY_CALC_W'(POLY_TEN) << FRAC_BITS)
                - POLY_CALC_W'(POLY_FIFTEEN) * POLY_CALC_W'(tau_ff)
                + POLY_CALC_W'(POLY_SIX) * POLY_CALC_W'(tau2_ff);
      poly      = poly_raw[POLY_CALC_W-1] ? '0 : poly_raw[POLY_W-1:0];
      pos_diff  = {end_ff[POS_W-1], end_ff} - {start_ff[POS_W-1], start_ff};
      pos_mag   = pos_diff[POS_W] ? -pos_diff : pos_diff;
      pos_step  = mul_p[FRAC_BITS +: (POS_W+1)];
      pos_delta = sign_ff ? -pos_step : pos_step;
      mot_diff  = {setpoint_ff[POS_W-1], setpoint_ff}
                - {zero_offset_ff[POS_W-1], zero_offset_ff};
      mot_mag   = mot_diff[POS_W] ? -mot_diff : mot_diff;
      ang_mag   = mul_p[MUL_P_W-1:FRAC_BITS];
      // Saturate the signed motor angle to the 32-bit range.
      if (sign_ff) begin
         ang_sat = (ang_mag > ANG_MAG_W'(POS_MIN)) ? POS_MIN : -ang_mag[POS_W-1:0];
      end else begin
         ang_sat = (ang_mag > ANG_MAG_W'(POS_MAX)) ? POS_MAX : ang_mag[POS_W-1:0];
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (div_go) begin
               state_in = ST_DIVIDE;
            end else if (func_ff == FUNC_TICK) begin
               state_in = ST_MOTOR;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            if (div_done) state_in = ST_TAU2;
         end
         ST_TAU2:       state_in = ST_TAU3;
         ST_TAU3:       state_in = ST_SCALE;
         ST_SCALE:      state_in = ST_POS;
         ST_POS:        state_in = ST_POS_DONE;
         ST_POS_DONE:   state_in = ST_MOTOR;
         ST_MOTOR:      state_in = ST_MOTOR_DONE;
         ST_MOTOR_DONE: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: ready, divider start and multiplier operands.
   always_comb begin
      req_tready       = 1'b0;
      div_req.start    = div_go;
      div_req.dividend = t_sum[TIME_W-1:0];
      div_req.divisor  = move_time_ff;
      mul_a            = '0;
      mul_b            = '0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_TAU2: begin
            mul_a = MUL_A_W'(tau_ff);
            mul_b = MUL_B_W'(tau_ff);
         end
         ST_TAU3: begin
            mul_a = MUL_A_W'(tau_ff);
            mul_b = MUL_B_W'(mul_p[FRAC_BITS +: FRAC_BITS]);
         end
         ST_SCALE: begin
            mul_a = MUL_A_W'(mul_p[FRAC_BITS +: FRAC_BITS]);
            mul_b = MUL_B_W'(poly);
         end
         ST_POS: begin
            mul_a = pos_mag;
            mul_b = MUL_B_W'(mul_p[FRAC_BITS +: POLY_W]);
         end
         ST_MOTOR: begin
            mul_a = mot_mag;
            mul_b = MUL_B_W'(gear_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Register writes from the control channel.
   always_comb begin
      csr_ready      = 1'b1;
      time_step_in   = time_step_ff;
      lower_limit_in = lower_limit_ff;
      upper_limit_in = upper_limit_ff;
      zero_offset_in = zero_offset_ff;
      reverse_in     = reverse_ff;
      gear_in        = gear_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TIME_STEP:   time_step_in   = csr_data[STEP_W-1:0];
            CSR_LOWER_LIMIT: lower_limit_in = csr_data[POS_W-1:0];
            CSR_UPPER_LIMIT: upper_limit_in = csr_data[POS_W-1:0];
            CSR_ZERO_OFFSET: zero_offset_in = csr_data[POS_W-1:0];
            CSR_REVERSE:     reverse_in     = csr_data[0];
            CSR_GEAR_RATIO:  gear_in        = csr_data[GEAR_W-1:0];
            default:         time_step_in   = time_step_ff;
         endcase
      end
   end

   // Trajectory state and working registers.
   always_comb begin
      start_in       = start_ff;
      end_in         = end_ff;
      move_time_in   = move_time_ff;
      elapsed_in     = elapsed_ff;
      planning_in    = planning_ff;
      setpoint_in    = setpoint_ff;
      func_in        = func_ff;
      target_in      = target_ff;
      duration_in    = duration_ff;
      tau_in         = tau_ff;
      tau2_in        = tau2_ff;
      sign_in        = sign_ff;
      angle_in       = angle_ff;
      motor_valid_in = motor_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in     = func_type'(req_tuser);
               target_in   = req_tdata[POS_W-1:0];
               duration_in = req_tdata[POS_W +: TIME_W];
            end
         end
         ST_DECODE: begin
            angle_in       = '0;
            motor_valid_in = 1'b0;
            case (func_ff)
               FUNC_TICK: begin
                  if (planning_ff) begin
                     if (t_done) begin
                        elapsed_in  = move_time_ff;
                        planning_in = 1'b0;
                        setpoint_in = end_ff;
                     end else begin
                        elapsed_in = t_sum[TIME_W-1:0];
                     end
                  end
               end
               FUNC_MOVE: begin
                  if (move_ok) begin
                     start_in     = setpoint_ff;
                     end_in       = target_ff;
                     move_time_in = duration_ff;
                     elapsed_in   = '0;
                     planning_in  = 1'b1;
                  end
               end
               FUNC_FORCE: begin
                  start_in    = target_ff;
                  end_in      = target_ff;
                  setpoint_in = target_ff;
                  planning_in = 1'b0;
               end
               default: begin
                  planning_in = planning_ff;
               end
            endcase
         end
         ST_DIVIDE: begin
            if (div_done) tau_in = div_quot;
         end
         ST_TAU3:       tau2_in = mul_p[FRAC_BITS +: FRAC_BITS];
         ST_POS:        sign_in = pos_diff[POS_W];
         ST_POS_DONE:   setpoint_in = start_ff + pos_delta[POS_W-1:0];
         ST_MOTOR:      sign_in = mot_diff[POS_W] ^ reverse_ff;
         ST_MOTOR_DONE: begin
            angle_in       = setpoint_ok ? ang_sat : '0;
            motor_valid_in = setpoint_ok;
         end
         default: begin
            sign_in = sign_ff;
         end
      endcase
   end

   // Response register: loaded at the end of each request, cleared when taken.
   always_comb begin
      rsp_valid_in       = rsp_valid_ff && !rsp_tready;
      rsp_setpoint_in    = rsp_setpoint_ff;
      rsp_angle_in       = rsp_angle_ff;
      rsp_motor_valid_in = rsp_motor_valid_ff;
      rsp_moving_in      = rsp_moving_ff;
      if ((state_ff == ST_FINISH) && rsp_free) begin
         rsp_valid_in       = 1'b1;
         rsp_setpoint_in    = setpoint_ff;
         rsp_angle_in       = angle_ff;
         rsp_motor_valid_in = motor_valid_ff;
         rsp_moving_in      = planning_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff   <= TIME_STEP_RESET;
         lower_limit_ff <= POS_MIN;
         upper_limit_ff <= POS_MAX;
         zero_offset_ff <= '0;
         reverse_ff     <= 1'b0;
         gear_ff        <= GEAR_RESET;
         start_ff       <= '0;
         end_ff         <= '0;
         move_time_ff   <= '0;
         elapsed_ff     <= '0;
         planning_ff    <= 1'b0;
         setpoint_ff    <= '0;
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         time_step_ff   <= time_step_in;
         lower_limit_ff <= lower_limit_in;
         upper_limit_ff <= upper_limit_in;
         zero_offset_ff <= zero_offset_in;
         reverse_ff     <= reverse_in;
         gear_ff        <= gear_in;
         start_ff       <= start_in;
         end_ff         <= end_in;
         move_time_ff   <= move_time_in;
         elapsed_ff     <= elapsed_in;
         planning_ff    <= planning_in;
         setpoint_ff    <= setpoint_in;
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      func_ff            <= func_in;
      target_ff          <= target_in;
      duration_ff        <= duration_in;
      tau_ff             <= tau_in;
      tau2_ff            <= tau2_in;
      sign_ff            <= sign_in;
      angle_ff           <= angle_in;
      motor_valid_ff     <= motor_valid_in;
      rsp_setpoint_ff    <= rsp_setpoint_in;
      rsp_angle_ff       <= rsp_angle_in;
      rsp_motor_valid_ff <= rsp_motor_valid_in;
      rsp_moving_ff      <= rsp_moving_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_angle_ff, rsp_setpoint_ff};
   assign rsp_tuser  = {rsp_moving_ff, rsp_motor_valid_ff};

   // A move in progress always has a nonzero duration and time left to run.
   a_move_time_set: assert property (@(posedge clock) disable iff (reset)
      planning_ff |-> (move_time_ff != '0))
      else $error("move in progress with zero duration");

   a_elapsed_below: assert property (@(posedge clock) disable iff (reset)
      planning_ff |-> (elapsed_ff < move_time_ff))
      else $error("elapsed time reached duration during a move");

   // The divider only reports back while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide step");

   // A motor angle is only reported for a tick.
   a_motor_only_tick: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && motor_valid_ff) |-> (func_ff == FUNC_TICK))
      else $error("motor angle marked valid for a non-tick request");

endmodule

`default_nettype wire

// ===== dv/tb_quintic_joint_trajectory_unit.sv =====
module tb_quintic_joint_trajectory_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import qjt_pkg::*;

   localparam int     LONG_HOLD_CYCLES = 400;
   localparam int     DRAIN_CYCLES     = 60;
   localparam int     PHASE_REQUESTS   = 150;
   localparam longint ONE_Q            = longint'(1) << FRAC_BITS;
   localparam longint POS_HI           = longint'($signed(POS_MAX));
   localparam longint POS_LO           = longint'($signed(POS_MIN));

   // One response as the joint should report it.
   typedef struct {
      logic [POS_W-1:0] setpoint;
      logic [POS_W-1:0] motor_angle;
      logic             motor_valid;
      logic             moving;
   } joint_report_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [FUNC_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DAT_W-1:0]  csr_data;

   // Mirror of the joint registers and trajectory state.
   logic [STEP_W-1:0]     j_step;
   longint                j_lower;
   longint                j_upper;
   longint                j_offset;
   logic                  j_reverse;
   logic [GEAR_W-1:0]     j_gear;
   longint                j_start;
   longint                j_end;
   longint                j_setpoint;
   longint unsigned       j_move_time;
   longint unsigned       j_elapsed;
   logic                  j_moving;

   joint_report_type      pending_reports[$];
   int                    mismatch_count  = 0;
   int                    requests_sent   = 0;
   int                    reports_checked = 0;
   int                    moves_planned   = 0;
   int                    moves_completed = 0;
   int                    angles_clamped  = 0;
   int                    settings_used   = 0;
   int                    hold_ticket     = 0;
   int                    hold_served     = 0;
   logic                  req_idle_on;
   logic                  rsp_idle_on;

   quintic_joint_trajectory_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // target, duration
      .req_tuser  (req_tuser),   // func
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // setpoint, motor_angle
      .rsp_tuser  (rsp_tuser),   // motor_valid, moving
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Fixed-point product scaled down by the fraction width, truncated towards zero.
   function automatic longint mul_frac(longint a, longint b);
      logic            negative;
      longint unsigned mag_a;
      longint unsigned mag_b;
      longint unsigned prod;
      negative = (a < 0) != (b < 0);
      mag_a    = (a < 0) ? -a : a;
      mag_b    = (b < 0) ? -b : b;
      prod     = (mag_a * mag_b) >> FRAC_BITS;
      return negative ? -longint'(prod) : longint'(prod);
   endfunction

   function automatic logic within_limits(longint value);
      return value >= j_lower && value <= j_upper;
   endfunction

   // One control tick along the minimum-jerk curve.
   function automatic void advance_curve();
      longint unsigned t;
      longint unsigned tau;
      longint unsigned tau2;
      longint unsigned tau3;
      longint          poly;
      longint          blend;
      if (!j_moving) return;
      t = j_elapsed + j_step;
      if (t >= j_move_time || j_move_time == 0) begin
         j_elapsed  = j_move_time;
         j_moving   = 1'b0;
         j_setpoint = j_end;
         moves_completed++;
         return;
      end
      j_elapsed = t;
      tau  = (t << FRAC_BITS) / j_move_time;
      tau2 = (tau * tau) >> FRAC_BITS;
      tau3 = (tau2 * tau) >> FRAC_BITS;
      poly = POLY_TEN * ONE_Q - POLY_FIFTEEN * longint'(tau) + POLY_SIX * longint'(tau2);
      if (poly < 0) poly = 0;
      blend = longint'((tau3 * longint'(poly)) >> FRAC_BITS);
      j_setpoint = j_start + mul_frac(j_end - j_start, blend);
   endfunction

   // Apply one accepted request to the mirror and return the report it causes.
   function automatic joint_report_type predict_joint_request(func_type func,
                                                              logic [POS_W-1:0] target,
                                                              logic [TIME_W-1:0] duration);
      joint_report_type rep;
      longint           goal;
      longint           angle;
      goal            = $signed(target);
      angle           = 0;
      rep.motor_valid = 1'b0;
      case (func)
         FUNC_TICK: begin
            advance_curve();
            if (within_limits(j_setpoint)) begin
               angle = mul_frac(j_setpoint - j_offset, longint'(j_gear));
               if (j_reverse) angle = -angle;
               if (angle > POS_HI || angle < POS_LO) angles_clamped++;
               if (angle > POS_HI) angle = POS_HI;
               if (angle < POS_LO) angle = POS_LO;
               rep.motor_valid = 1'b1;
            end
         end
         FUNC_MOVE: begin
            if (!j_moving && within_limits(goal) && duration != 0) begin
               j_start     = j_setpoint;
               j_end       = goal;
               j_move_time = duration;
               j_elapsed   = 0;
               j_moving    = 1'b1;
               moves_planned++;
            end
         end
         FUNC_FORCE: begin
            j_start    = goal;
            j_end      = goal;
            j_setpoint = goal;
            j_moving   = 1'b0;
         end
         default: begin
         end
      endcase
      rep.setpoint    = j_setpoint[POS_W-1:0];
      rep.motor_angle = angle[POS_W-1:0];
      rep.moving      = j_moving;
      return rep;
   endfunction

   // A position inside the present limits, now and then one of the limits itself.
   function automatic logic [POS_W-1:0] pick_in_limits();
      longint unsigned span;
      longint unsigned offs;
      case ($urandom_range(0, 7))
         0: return POS_W'(j_lower);
         1: return POS_W'(j_upper);
         default: begin
            span = j_upper - j_lower;
            offs = {$urandom, $urandom} % (span + 1);
            return POS_W'(j_lower + longint'(offs));
         end
      endcase
   endfunction

   // Offer one request and record its report once it is taken.
   task automatic send_request(func_type func, logic [POS_W-1:0] target,
                               logic [TIME_W-1:0] duration);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {duration, target};
      do @(posedge clock); while (!req_tready);
      pending_reports.push_back(predict_joint_request(func, target, duration));
      requests_sent++;
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Stop offering requests and let the block drain completely.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TIME_STEP:   j_step    = value[STEP_W-1:0];
         CSR_LOWER_LIMIT: j_lower   = $signed(value);
         CSR_UPPER_LIMIT: j_upper   = $signed(value);
         CSR_ZERO_OFFSET: j_offset  = $signed(value);
         CSR_REVERSE:     j_reverse = value[0];
         CSR_GEAR_RATIO:  j_gear    = value[GEAR_W-1:0];
         default: begin
         end
      endcase
   endtask

   // Write the whole register set; the block must be idle.
   task automatic program_registers(logic [STEP_W-1:0] step, logic [POS_W-1:0] lower,
                                    logic [POS_W-1:0] upper, logic [POS_W-1:0] offset,
                                    logic reverse, logic [GEAR_W-1:0] gear);
      write_register(CSR_TIME_STEP, CSR_DAT_W'(step));
      write_register(CSR_LOWER_LIMIT, lower);
      write_register(CSR_UPPER_LIMIT, upper);
      write_register(CSR_ZERO_OFFSET, offset);
      write_register(CSR_REVERSE, CSR_DAT_W'(reverse));
      write_register(CSR_GEAR_RATIO, CSR_DAT_W'(gear));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Moves with the reset register values: extreme targets, rejections and the unused code.
   task automatic test_directed_moves();
      send_request(FUNC_TICK, '0, '0);
      send_request(FUNC_MOVE, POS_MAX, 32'd208);
      send_request(FUNC_MOVE, POS_W'(ONE_Q), TIME_W'(ONE_Q));
      repeat (4) send_request(FUNC_TICK, $urandom, $urandom);
      send_request(FUNC_NONE, $urandom, $urandom);
      send_request(FUNC_MOVE, POS_W'(ONE_Q), '0);
      send_request(FUNC_FORCE, POS_MIN, '0);
      send_request(FUNC_TICK, '0, '0);
      send_request(FUNC_MOVE, POS_MAX, '1);
      send_request(FUNC_TICK, '0, '0);
      send_request(FUNC_FORCE, '0, '0);
      settle_block();
   endtask

   // Limit checks, saturation of the motor angle and crossed limits.
   task automatic test_limits_and_mapping();
      program_registers(TIME_STEP_RESET, POS_W'(-100 * ONE_Q), POS_W'(100 * ONE_Q),
                        POS_W'(-90 * ONE_Q), 1'b1, '1);
      send_request(FUNC_FORCE, POS_MAX, '0);
      send_request(FUNC_TICK, '0, '0);
      send_request(FUNC_MOVE, POS_W'(200 * ONE_Q), TIME_W'(ONE_Q));
      send_request(FUNC_FORCE, POS_W'(90 * ONE_Q), '0);
      send_request(FUNC_TICK, '0, '0);
      send_request(FUNC_MOVE, POS_W'(-100 * ONE_Q), 32'd132);
      repeat (2) send_request(FUNC_TICK, '0, '0);
      settle_block();

      // A lower limit above the upper one admits no move and no motor angle.
      program_registers(TIME_STEP_RESET, POS_W'(ONE_Q), POS_W'(-ONE_Q), '0, 1'b0, '0);
      send_request(FUNC_MOVE, '0, TIME_W'(ONE_Q));
      send_request(FUNC_TICK, '0, '0);
      settle_block();
   endtask

   // With a zero step the move stays at its start until a forced position ends it.
   task automatic test_zero_time_step();
      program_registers('0, POS_MIN, POS_MAX, '0, 1'b0, GEAR_RESET);
      send_request(FUNC_FORCE, '0, '0);
      send_request(FUNC_MOVE, POS_W'(ONE_Q), 32'd100);
      send_request(FUNC_TICK, '0, '0);
      send_request(FUNC_FORCE, POS_W'(5 * ONE_Q), '0);
      settle_block();
   endtask

   // The receiver holds off for a long time while requests keep coming.
   task automatic test_backpressure();
      program_registers(STEP_W'(1000), POS_MIN, POS_MAX, $urandom, 1'b0, GEAR_RESET);
      req_idle_on = 1'b0;
      hold_ticket <= hold_ticket + 1;
      send_request(FUNC_FORCE, '0, '0);
      send_request(FUNC_MOVE, pick_in_limits(), TIME_W'(8000 + $urandom_range(0, 999)));
      repeat (12) send_request(FUNC_TICK, '0, '0);
      settle_block();
      req_idle_on = 1'b1;
   endtask

   // Random phases: mostly whole moves with random content, the rest noise.
   task automatic test_random_phases();
      int                phase;
      int                phase_base;
      int                steps;
      int                step_now;
      logic [POS_W-1:0]  lo;
      logic [POS_W-1:0]  hi;
      logic [POS_W-1:0]  swap;
      for (phase = 0; phase < 6; phase++) begin
         lo = $urandom;
         hi = $urandom;
         if ($signed(lo) > $signed(hi)) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
         end
         case (phase)
            0: program_registers(TIME_STEP_RESET, POS_MIN, POS_MAX, '0, 1'b0, GEAR_RESET);
            1: program_registers('1, lo, hi, $urandom, 1'b1, GEAR_W'($urandom));
            2: program_registers(STEP_W'(1), POS_MIN, POS_MAX, $urandom, 1'b0, '0);
            3: program_registers(STEP_W'($urandom_range(1, 65535)), lo, hi, $urandom, 1'b1, '1);
            default: program_registers(STEP_W'($urandom_range(1, 65535)), lo, hi, $urandom,
                                       1'($urandom), GEAR_W'($urandom));
         endcase
         // The closing phase runs with no idling on either side.
         if (phase == 5) begin
            req_idle_on = 1'b0;
            rsp_idle_on <= 1'b0;
         end
         phase_base = requests_sent;
         while (requests_sent - phase_base < PHASE_REQUESTS) begin
            if ($urandom_range(0, 4) == 0) begin
               send_request(func_type'($urandom_range(0, 3)), $urandom,
                            ($urandom_range(0, 7) == 0) ? '0 : $urandom);
            end else begin
               if (j_moving || $urandom_range(0, 2) == 0) begin
                  send_request(FUNC_FORCE, $urandom_range(0, 1) ? pick_in_limits() : $urandom,
                               $urandom);
               end
               step_now = j_step;
               steps    = $urandom_range(1, 20);
               send_request(FUNC_MOVE, pick_in_limits(),
                            TIME_W'(step_now * steps + $urandom_range(0, step_now - 1)));
               repeat (steps + 2) begin
                  case ($urandom_range(0, 23))
                     0: send_request(FUNC_MOVE, pick_in_limits(), $urandom);
                     1: send_request(FUNC_FORCE, $urandom, $urandom);
                     default: send_request(FUNC_TICK, $urandom, $urandom);
                  endcase
               end
            end
         end
         settle_block();
      end
   endtask

   // Main sequence.
   initial begin
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = FUNC_TICK;
      csr_valid   = 1'b0;
      csr_index   = CSR_TIME_STEP;
      csr_data    = '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      reset       = 1'b1;
      j_step      = TIME_STEP_RESET;
      j_lower     = POS_LO;
      j_upper     = POS_HI;
      j_offset    = 0;
      j_reverse   = 1'b0;
      j_gear      = GEAR_RESET;
      j_start     = 0;
      j_end       = 0;
      j_setpoint  = 0;
      j_move_time = 0;
      j_elapsed   = 0;
      j_moving    = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_moves();
      test_limits_and_mapping();
      test_zero_time_step();
      test_backpressure();
      test_random_phases();

      $display("Covered %0d requests and %0d checked reports across %0d register settings.",
               requests_sent, reports_checked, settings_used);
      $display("Planned %0d moves, %0d ran to their end; %0d motor angles were clamped.",
               moves_planned, moves_completed, angles_clamped);
      if (mismatch_count == 0) begin
         $display("quintic_joint_trajectory_unit verification clean");
      end else begin
         $display("quintic_joint_trajectory_unit verification failed");
      end
      $finish;
   end

   // Receiver: random stall bursts, plus a long hold-off whenever one is asked for.
   initial begin : rsp_side
      int held;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_ticket != hold_served) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < LONG_HOLD_CYCLES; held++) @(posedge clock);
            hold_served = hold_ticket;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic compare_field(string field, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Each report taken from the block is compared with the oldest prediction.
   always @(posedge clock) begin : report_check
      joint_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t ns: unexpected report, expected none, actual data %h user %b",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("setpoint", want.setpoint, rsp_tdata[POS_W-1:0]);
            compare_field("motor_angle", want.motor_angle, rsp_tdata[2*POS_W-1:POS_W]);
            compare_field("motor_valid", POS_W'(want.motor_valid), POS_W'(rsp_tuser[0]));
            compare_field("moving", POS_W'(want.moving), POS_W'(rsp_tuser[1]));
            reports_checked++;
         end
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      #10_000_000;
      $display("quintic_joint_trajectory_unit verification failed");
      $finish;
   end

endmodule
